// ----- hdl/ecu_pkg.sv -----
package ecu_pkg;

    // Fixed-point format and internal value width
    localparam int FRAC_BITS = 15;
    localparam int VW        = 24;
    localparam int PW        = 2 * VW;
    localparam int LONG_SH   = FRAC_BITS + 6;

    typedef logic signed [VW-1:0] val_t;
    typedef logic signed [PW-1:0] prod_t;

    // Curve selector codes
    localparam logic [4:0] OP_LINEAR       = 5'd0;
    localparam logic [4:0] OP_QUAD_IN      = 5'd1;
    localparam logic [4:0] OP_QUAD_OUT     = 5'd2;
    localparam logic [4:0] OP_QUAD_INOUT   = 5'd3;
    localparam logic [4:0] OP_QUAD_OUTIN   = 5'd4;
    localparam logic [4:0] OP_CUBIC_IN     = 5'd5;
    localparam logic [4:0] OP_CUBIC_OUT    = 5'd6;
    localparam logic [4:0] OP_CUBIC_INOUT  = 5'd7;
    localparam logic [4:0] OP_QUART_IN     = 5'd8;
    localparam logic [4:0] OP_QUART_OUT    = 5'd9;
    localparam logic [4:0] OP_QUART_INOUT  = 5'd10;
    localparam logic [4:0] OP_QUINT_IN     = 5'd11;
    localparam logic [4:0] OP_QUINT_OUT    = 5'd12;
    localparam logic [4:0] OP_QUINT_INOUT  = 5'd13;
    localparam logic [4:0] OP_BACK_IN      = 5'd14;
    localparam logic [4:0] OP_BACK_OUT     = 5'd15;
    localparam logic [4:0] OP_BACK_INOUT   = 5'd16;
    localparam logic [4:0] OP_BOUNCE_IN    = 5'd17;
    localparam logic [4:0] OP_BOUNCE_OUT   = 5'd18;
    localparam logic [4:0] OP_BOUNCE_INOUT = 5'd19;

    // Curve constants in raw fixed point
    localparam val_t ONE      = val_t'(64'sd1 <<< FRAC_BITS);
    localparam val_t TWO      = val_t'(64'sd2 <<< FRAC_BITS);
    localparam val_t HALF_ONE = val_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam val_t BACK_S   = val_t'((64'sd170158 * (64'sd1 <<< FRAC_BITS) + 64'sd50000)
                                       / 64'sd100000);
    localparam val_t BACK_S2  = val_t'((64'sd25949095 * (64'sd1 <<< FRAC_BITS)
                                        + 64'sd5000000) / 64'sd10000000);
    localparam val_t BNC_T1   = val_t'(64'sd4 <<< FRAC_BITS);
    localparam val_t BNC_T2   = val_t'(64'sd8 <<< FRAC_BITS);
    localparam val_t BNC_T3   = val_t'(64'sd10 <<< FRAC_BITS);
    localparam val_t BNC_M1   = val_t'(64'sd12 <<< FRAC_BITS);
    localparam val_t BNC_M2   = val_t'(64'sd18 <<< FRAC_BITS);
    localparam val_t BNC_M3   = val_t'(64'sd21 <<< FRAC_BITS);
    localparam val_t BNC_K1   = val_t'((64'sd3 <<< FRAC_BITS) / 64'sd4);
    localparam val_t BNC_K2   = val_t'((64'sd15 <<< FRAC_BITS) / 64'sd16);
    localparam val_t BNC_K3   = val_t'((64'sd63 <<< FRAC_BITS) / 64'sd64);
    localparam val_t OUT_MAX  = val_t'(64'sd65535);
    localparam val_t OUT_MIN  = val_t'(-64'sd65536);

    localparam prod_t RND_STD  = prod_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam prod_t RND_LONG = prod_t'(64'sd1 <<< (LONG_SH - 1));

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic [2:0] nmul;
        logic       back;
        logic       bounce;
        logic       kneg;
        logic       s1neg;
        logic       halve;
        logic       s2neg;
        val_t       pre_add;
        val_t       post_add;
        val_t       back_off;
    } ctrl_t;

    // Products a*b rounded half up, shifted right by FRAC_BITS (or FRAC_BITS+6)
    function automatic val_t fx_mul(val_t a, val_t b, logic long_sh);
        prod_t prod;
        prod_t rnd;
        prod = prod_t'(a) * prod_t'(b);
        if (long_sh)
        begin
            rnd = (prod + RND_LONG) >>> LONG_SH;
        end
        else
        begin
            rnd = (prod + RND_STD) >>> FRAC_BITS;
        end
        return val_t'(rnd);
    endfunction

    // Number of multiplies after the first factor for the power curves
    function automatic logic [2:0] power_muls(logic [4:0] op);
        logic [2:0] n;
        unique case (op)
            OP_QUAD_IN, OP_QUAD_OUT, OP_QUAD_INOUT:    n = 3'd1;
            OP_CUBIC_IN, OP_CUBIC_OUT, OP_CUBIC_INOUT: n = 3'd2;
            OP_QUART_IN, OP_QUART_OUT, OP_QUART_INOUT: n = 3'd3;
            OP_QUINT_IN, OP_QUINT_OUT, OP_QUINT_INOUT: n = 3'd4;
            default:                                   n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/ecu_decode.sv -----
module ecu_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [4:0]           op,
    input  logic [15:0]          progress,
    output logic                 vld_out,
    output ecu_pkg::ctrl_t       ctrl_out,
    output ecu_pkg::val_t        ma_out,
    output ecu_pkg::val_t        mb_out,
    output ecu_pkg::val_t        mc_out,
    output ecu_pkg::val_t        md_out,
    output ecu_pkg::val_t        x_out
);

    ecu_pkg::val_t  ts;
    ecu_pkg::val_t  t2;
    logic           first;

    ecu_pkg::ctrl_t ctrl_a_next;
    ecu_pkg::val_t  x_a_next;
    ecu_pkg::val_t  c_a_next;

    logic           vld_a_reg;
    ecu_pkg::ctrl_t ctrl_a_reg;
    ecu_pkg::val_t  x_a_reg;
    ecu_pkg::val_t  c_a_reg;

    ecu_pkg::ctrl_t ctrl_b_next;
    ecu_pkg::val_t  x11;
    ecu_pkg::val_t  d_b;
    ecu_pkg::val_t  k_b;

    logic           vld_b_reg;
    ecu_pkg::ctrl_t ctrl_b_reg;
    ecu_pkg::val_t  ma_b_reg;
    ecu_pkg::val_t  mc_b_reg;
    ecu_pkg::val_t  x_b_reg;

    assign ts    = ecu_pkg::val_t'({{(ecu_pkg::VW - 16){1'b0}}, progress});
    assign t2    = ts <<< 1;
    assign first = (ts < ecu_pkg::HALF_ONE);

    // Pick the base argument and the combine recipe for each curve
    always_comb
    begin
        ctrl_a_next      = '0;
        x_a_next         = ts;
        c_a_next         = '0;
        ctrl_a_next.nmul = ecu_pkg::power_muls(op);
        unique case (op)
            ecu_pkg::OP_QUAD_IN, ecu_pkg::OP_CUBIC_IN,
            ecu_pkg::OP_QUART_IN, ecu_pkg::OP_QUINT_IN:
            begin
                x_a_next = ts;
            end
            ecu_pkg::OP_QUAD_OUT, ecu_pkg::OP_CUBIC_OUT,
            ecu_pkg::OP_QUART_OUT, ecu_pkg::OP_QUINT_OUT:
            begin
                x_a_next            = ecu_pkg::ONE - ts;
                ctrl_a_next.pre_add = ecu_pkg::ONE;
                ctrl_a_next.s1neg   = 1'b1;
            end
            ecu_pkg::OP_QUAD_INOUT, ecu_pkg::OP_CUBIC_INOUT,
            ecu_pkg::OP_QUART_INOUT, ecu_pkg::OP_QUINT_INOUT:
            begin
                ctrl_a_next.halve = 1'b1;
                if (first)
                begin
                    x_a_next = t2;
                end
                else
                begin
                    x_a_next             = ecu_pkg::TWO - t2;
                    ctrl_a_next.s2neg    = 1'b1;
                    ctrl_a_next.post_add = ecu_pkg::ONE;
                end
            end
            ecu_pkg::OP_QUAD_OUTIN:
            begin
                ctrl_a_next.nmul  = 3'd1;
                ctrl_a_next.halve = 1'b1;
                if (first)
                begin
                    x_a_next            = ecu_pkg::ONE - t2;
                    ctrl_a_next.pre_add = ecu_pkg::ONE;
                    ctrl_a_next.s1neg   = 1'b1;
                end
                else
                begin
                    x_a_next             = t2 - ecu_pkg::ONE;
                    ctrl_a_next.post_add = ecu_pkg::HALF_ONE;
                end
            end
            ecu_pkg::OP_BACK_IN:
            begin
                ctrl_a_next.nmul     = 3'd2;
                ctrl_a_next.back     = 1'b1;
                ctrl_a_next.back_off = -ecu_pkg::BACK_S;
                c_a_next             = ecu_pkg::BACK_S + ecu_pkg::ONE;
            end
            ecu_pkg::OP_BACK_OUT:
            begin
                ctrl_a_next.nmul     = 3'd2;
                ctrl_a_next.back     = 1'b1;
                ctrl_a_next.back_off = ecu_pkg::BACK_S;
                ctrl_a_next.pre_add  = ecu_pkg::ONE;
                c_a_next             = ecu_pkg::BACK_S + ecu_pkg::ONE;
                x_a_next             = ts - ecu_pkg::ONE;
            end
            ecu_pkg::OP_BACK_INOUT:
            begin
                ctrl_a_next.nmul  = 3'd2;
                ctrl_a_next.back  = 1'b1;
                ctrl_a_next.halve = 1'b1;
                c_a_next          = ecu_pkg::BACK_S2 + ecu_pkg::ONE;
                if (first)
                begin
                    x_a_next             = t2;
                    ctrl_a_next.back_off = -ecu_pkg::BACK_S2;
                end
                else
                begin
                    x_a_next             = t2 - ecu_pkg::TWO;
                    ctrl_a_next.back_off = ecu_pkg::BACK_S2;
                    ctrl_a_next.pre_add  = ecu_pkg::TWO;
                end
            end
            ecu_pkg::OP_BOUNCE_OUT:
            begin
                ctrl_a_next.nmul   = 3'd1;
                ctrl_a_next.bounce = 1'b1;
            end
            ecu_pkg::OP_BOUNCE_IN:
            begin
                ctrl_a_next.nmul     = 3'd1;
                ctrl_a_next.bounce   = 1'b1;
                ctrl_a_next.s2neg    = 1'b1;
                ctrl_a_next.post_add = ecu_pkg::ONE;
                x_a_next             = ecu_pkg::ONE - ts;
            end
            ecu_pkg::OP_BOUNCE_INOUT:
            begin
                ctrl_a_next.nmul   = 3'd1;
                ctrl_a_next.bounce = 1'b1;
                ctrl_a_next.halve  = 1'b1;
                if (first)
                begin
                    x_a_next            = ecu_pkg::ONE - t2;
                    ctrl_a_next.pre_add = ecu_pkg::ONE;
                    ctrl_a_next.kneg    = 1'b1;
                    ctrl_a_next.s1neg   = 1'b1;
                end
                else
                begin
                    x_a_next             = t2 - ecu_pkg::ONE;
                    ctrl_a_next.post_add = ecu_pkg::HALF_ONE;
                end
            end
            default:
            begin
                x_a_next = ts;
            end
        endcase
    end

    // Hold valid bits for both decode stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= vld_in;
            vld_b_reg <= vld_a_reg;
        end
    end

    // Capture the decoded word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            x_a_reg    <= x_a_next;
            c_a_reg    <= c_a_next;
        end
    end

    // Find the bounce segment: tests 11x against 4, 8 and 10
    assign x11 = (x_a_reg <<< 3) + (x_a_reg <<< 1) + x_a_reg;

    always_comb
    begin
        priority if (x11 < ecu_pkg::BNC_T1)
        begin
            d_b = x11 <<< 1;
            k_b = '0;
        end
        else if (x11 < ecu_pkg::BNC_T2)
        begin
            d_b = (x11 <<< 1) - ecu_pkg::BNC_M1;
            k_b = ecu_pkg::BNC_K1;
        end
        else if (x11 < ecu_pkg::BNC_T3)
        begin
            d_b = (x11 <<< 1) - ecu_pkg::BNC_M2;
            k_b = ecu_pkg::BNC_K2;
        end
        else
        begin
            d_b = (x11 <<< 1) - ecu_pkg::BNC_M3;
            k_b = ecu_pkg::BNC_K3;
        end
    end

    // Fold the bounce offset into the combine constant
    always_comb
    begin
        ctrl_b_next = ctrl_a_reg;
        if (ctrl_a_reg.bounce)
        begin
            ctrl_b_next.pre_add = ctrl_a_reg.kneg ? (ctrl_a_reg.pre_add - k_b)
                                                  : (ctrl_a_reg.pre_add + k_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_b_reg <= ctrl_b_next;
            ma_b_reg   <= ctrl_a_reg.bounce ? d_b : x_a_reg;
            mc_b_reg   <= c_a_reg;
            x_b_reg    <= x_a_reg;
        end
    end

    assign vld_out  = vld_b_reg;
    assign ctrl_out = ctrl_b_reg;
    assign ma_out   = ma_b_reg;
    assign mb_out   = ma_b_reg;
    assign mc_out   = mc_b_reg;
    assign md_out   = x_b_reg;
    assign x_out    = x_b_reg;

endmodule

// ----- hdl/ecu_mult.sv -----
module ecu_mult (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  ecu_pkg::ctrl_t  ctrl_in,
    input  ecu_pkg::val_t   ma,
    input  ecu_pkg::val_t   mb,
    input  ecu_pkg::val_t   mc,
    input  ecu_pkg::val_t   md,
    input  ecu_pkg::val_t   x_in,
    output logic            vld_out,
    output ecu_pkg::ctrl_t  ctrl_out,
    output ecu_pkg::val_t   p_out
);

    logic [3:0]     vld_reg;
    ecu_pkg::ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    ecu_pkg::val_t  x1_reg, x2_reg, x3_reg;
    ecu_pkg::val_t  p1_reg, p2_reg, p3_reg, p4_reg;
    ecu_pkg::val_t  q1_reg;

    ecu_pkg::val_t  p1_next, p2_next, p3_next, p4_next;
    ecu_pkg::val_t  q1_next;
    ecu_pkg::val_t  m2_op;

    // First product; back curves also form the slope term alongside
    assign p1_next = (ctrl_in.nmul != 3'd0) ? ecu_pkg::fx_mul(ma, mb, ctrl_in.bounce) : ma;
    assign q1_next = ecu_pkg::fx_mul(mc, md, 1'b0);

    // Second product: by x for powers, by the offset slope for back
    assign m2_op   = ctrl1_reg.back ? (q1_reg + ctrl1_reg.back_off) : x1_reg;
    assign p2_next = (ctrl1_reg.nmul >= 3'd2) ? ecu_pkg::fx_mul(p1_reg, m2_op, 1'b0)
                                              : p1_reg;
    assign p3_next = (ctrl2_reg.nmul >= 3'd3) ? ecu_pkg::fx_mul(p2_reg, x2_reg, 1'b0)
                                              : p2_reg;
    assign p4_next = (ctrl3_reg.nmul >= 3'd4) ? ecu_pkg::fx_mul(p3_reg, x3_reg, 1'b0)
                                              : p3_reg;

    // Advance valid bits with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl1_reg <= ctrl_in;
            x1_reg    <= x_in;
            p1_reg    <= p1_next;
            q1_reg    <= q1_next;
            ctrl2_reg <= ctrl1_reg;
            x2_reg    <= x1_reg;
            p2_reg    <= p2_next;
            ctrl3_reg <= ctrl2_reg;
            x3_reg    <= x2_reg;
            p3_reg    <= p3_next;
            ctrl4_reg <= ctrl3_reg;
            p4_reg    <= p4_next;
        end
    end

    assign vld_out  = vld_reg[3];
    assign ctrl_out = ctrl4_reg;
    assign p_out    = p4_reg;

endmodule

// ----- hdl/ecu_post.sv -----
module ecu_post (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  ecu_pkg::ctrl_t      ctrl_in,
    input  ecu_pkg::val_t       p_in,
    output logic                vld_out,
    output logic signed [16:0]  eased_out
);

    ecu_pkg::val_t        v1;
    ecu_pkg::val_t        h;
    ecu_pkg::val_t        r;
    logic signed [16:0]   eased_next;
    logic                 vld_reg;
    logic signed [16:0]   eased_reg;

    // Combine: post +- h(pre +- p), h optionally a rounded halving
    assign v1 = ctrl_in.s1neg ? (ctrl_in.pre_add - p_in) : (ctrl_in.pre_add + p_in);
    assign h  = ctrl_in.halve ? ((v1 + ecu_pkg::val_t'(1)) >>> 1) : v1;
    assign r  = ctrl_in.s2neg ? (ctrl_in.post_add - h) : (ctrl_in.post_add + h);

    // Saturate to the output range
    always_comb
    begin
        priority if (r > ecu_pkg::OUT_MAX)
        begin
            eased_next = r[16:0];
            eased_next = 17'sh0FFFF;
        end
        else if (r < ecu_pkg::OUT_MIN)
        begin
            eased_next = 17'sh10000;
        end
        else
        begin
            eased_next = r[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eased_reg <= eased_next;
        end
    end

    assign vld_out   = vld_reg;
    assign eased_out = eased_reg;

endmodule

// ----- hdl/easing_curve_unit.sv -----
// Channel | Handshake            | Word
// --------+----------------------+---------------------------------------
// input   | in_valid / in_ready  | op[4:0], progress[15:0] (unsigned)
// output  | out_valid / out_ready| eased[16:0] (signed, 15 fraction bits)
//
// One word enters per cycle while no output word is held waiting; each result
// passes through two decode stages, four multiplier stages and the output
// register that combines, halves and saturates.
// Reset clears only the valid bits; the data registers keep whatever they held.
// A waiting output word freezes the whole pipeline, so in_ready drops only
// while out_valid is high and out_ready is low.
module easing_curve_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         op,
    input  logic [15:0]        progress,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] eased
);

    logic           en;
    logic           dec_vld;
    ecu_pkg::ctrl_t dec_ctrl;
    ecu_pkg::val_t  dec_ma, dec_mb, dec_mc, dec_md, dec_x;
    logic           mul_vld;
    ecu_pkg::ctrl_t mul_ctrl;
    ecu_pkg::val_t  mul_p;

    // Advance every stage unless the output word is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    ecu_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (in_valid),
        .op       (op),
        .progress (progress),
        .vld_out  (dec_vld),
        .ctrl_out (dec_ctrl),
        .ma_out   (dec_ma),
        .mb_out   (dec_mb),
        .mc_out   (dec_mc),
        .md_out   (dec_md),
        .x_out    (dec_x)
    );

    ecu_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (dec_vld),
        .ctrl_in  (dec_ctrl),
        .ma       (dec_ma),
        .mb       (dec_mb),
        .mc       (dec_mc),
        .md       (dec_md),
        .x_in     (dec_x),
        .vld_out  (mul_vld),
        .ctrl_out (mul_ctrl),
        .p_out    (mul_p)
    );

    ecu_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vld_in    (mul_vld),
        .ctrl_in   (mul_ctrl),
        .p_in      (mul_p),
        .vld_out   (out_valid),
        .eased_out (eased)
    );

`ifndef SYNTH
    // A word taken in emerges at the output if the pipeline then flows freely
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
        ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("pipeline lost a word");

    // An output word leaves only when taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("output word dropped without handshake");
`endif

endmodule

// ----- tb/easing_curve_checker.sv -----
`timescale 1ns / 1ps

module easing_curve_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [4:0]         op,
    input  logic [15:0]        progress,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [16:0] eased,
    output int                 mismatches,
    output int                 pending,
    output int                 checked
);

    localparam longint UNIT  = longint'(1) << ecu_pkg::FRAC_BITS;
    localparam longint BOUND = longint'(1) << 31;
    localparam longint SLOPE = (longint'(170158) * UNIT + 50000) / 100000;
    localparam longint SLOPE2 = (longint'(25949095) * UNIT + 5000000) / 10000000;

    logic signed [16:0] eased_q[$];

    function automatic longint clip(longint v);
        if (v > BOUND)
        begin
            return BOUND;
        end
        if (v < -BOUND)
        begin
            return -BOUND;
        end
        return v;
    endfunction

    // round half up: arithmetic shift of a signed value is a floor
    function automatic longint rnd_shift(longint p, int s);
        longint q;
        q = p + (longint'(1) << (s - 1));
        return q >>> s;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return clip(rnd_shift(clip(a) * clip(b), ecu_pkg::FRAC_BITS));
    endfunction

    function automatic longint halve(longint x);
        return rnd_shift(clip(x), 1);
    endfunction

    function automatic longint power(longint x, int n);
        longint p;
        p = clip(x);
        for (int i = 1; i < n; i++)
        begin
            p = fmul(p, x);
        end
        return p;
    endfunction

    function automatic longint curve_out(longint t, int n);
        return UNIT - power(UNIT - t, n);
    endfunction

    function automatic longint curve_in_out(longint t, int n);
        longint t2;
        t2 = 2 * t;
        if (t2 < UNIT)
        begin
            return halve(power(t2, n));
        end
        return UNIT - halve(power(2 * UNIT - t2, n));
    endfunction

    function automatic longint overshoot_in(longint t, longint s);
        return fmul(fmul(t, t), fmul(s + UNIT, t) - s);
    endfunction

    function automatic longint overshoot_out(longint t, longint s);
        longint u;
        u = t - UNIT;
        return fmul(fmul(u, u), fmul(s + UNIT, u) + s) + UNIT;
    endfunction

    function automatic longint bounce_fall(longint t);
        longint d;
        longint k;
        if (11 * t < 4 * UNIT)
        begin
            d = 22 * t;
            k = 0;
        end
        else if (11 * t < 8 * UNIT)
        begin
            d = 22 * t - 12 * UNIT;
            k = (3 * UNIT) / 4;
        end
        else if (11 * t < 10 * UNIT)
        begin
            d = 22 * t - 18 * UNIT;
            k = (15 * UNIT) / 16;
        end
        else
        begin
            d = 22 * t - 21 * UNIT;
            k = (63 * UNIT) / 64;
        end
        return rnd_shift(d * d, ecu_pkg::FRAC_BITS + 6) + k;
    endfunction

    function automatic longint bounce_rise(longint t);
        return UNIT - bounce_fall(UNIT - t);
    endfunction

    function automatic logic signed [16:0] ease_value(logic [4:0] sel, logic [15:0] prog);
        longint t;
        longint r;
        longint u;
        t = longint'(prog);
        case (sel)
            ecu_pkg::OP_QUAD_IN:      r = power(t, 2);
            ecu_pkg::OP_QUAD_OUT:     r = curve_out(t, 2);
            ecu_pkg::OP_QUAD_INOUT:   r = curve_in_out(t, 2);
            ecu_pkg::OP_QUAD_OUTIN:
            begin
                if (2 * t < UNIT)
                begin
                    r = halve(curve_out(2 * t, 2));
                end
                else
                begin
                    r = halve(power(2 * t - UNIT, 2)) + UNIT / 2;
                end
            end
            ecu_pkg::OP_CUBIC_IN:     r = power(t, 3);
            ecu_pkg::OP_CUBIC_OUT:    r = curve_out(t, 3);
            ecu_pkg::OP_CUBIC_INOUT:  r = curve_in_out(t, 3);
            ecu_pkg::OP_QUART_IN:     r = power(t, 4);
            ecu_pkg::OP_QUART_OUT:    r = curve_out(t, 4);
            ecu_pkg::OP_QUART_INOUT:  r = curve_in_out(t, 4);
            ecu_pkg::OP_QUINT_IN:     r = power(t, 5);
            ecu_pkg::OP_QUINT_OUT:    r = curve_out(t, 5);
            ecu_pkg::OP_QUINT_INOUT:  r = curve_in_out(t, 5);
            ecu_pkg::OP_BACK_IN:      r = overshoot_in(t, SLOPE);
            ecu_pkg::OP_BACK_OUT:     r = overshoot_out(t, SLOPE);
            ecu_pkg::OP_BACK_INOUT:
            begin
                if (2 * t < UNIT)
                begin
                    r = halve(overshoot_in(2 * t, SLOPE2));
                end
                else
                begin
                    u = 2 * t - 2 * UNIT;
                    r = halve(fmul(fmul(u, u), fmul(SLOPE2 + UNIT, u) + SLOPE2) + 2 * UNIT);
                end
            end
            ecu_pkg::OP_BOUNCE_IN:    r = bounce_rise(t);
            ecu_pkg::OP_BOUNCE_OUT:   r = bounce_fall(t);
            ecu_pkg::OP_BOUNCE_INOUT:
            begin
                if (2 * t < UNIT)
                begin
                    r = halve(bounce_rise(2 * t));
                end
                else
                begin
                    r = halve(bounce_fall(2 * t - UNIT)) + UNIT / 2;
                end
            end
            default:         r = t;
        endcase
        // saturate to the output range
        if (r > 65535)
        begin
            r = 65535;
        end
        if (r < -65536)
        begin
            r = -65536;
        end
        return r[16:0];
    endfunction

    task automatic report(string what, logic signed [16:0] got, logic signed [16:0] want);
        $display("%0t ns: MISMATCH %s: eased got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        checked    = 0;
        pending    = 0;
    end

    // queue each accepted word's expected value, compare each delivered word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                eased_q.push_back(ease_value(op, progress));
            end
            if (out_valid && out_ready)
            begin
                if (eased_q.size() == 0)
                begin
                    report("unexpected word", eased, 'x);
                end
                else
                begin
                    logic signed [16:0] want;
                    want = eased_q.pop_front();
                    if (eased !== want)
                    begin
                        report("value", eased, want);
                    end
                    checked++;
                end
            end
            pending = eased_q.size();
        end
    end

endmodule

// ----- tb/easing_curve_unit_tb.sv -----
`timescale 1ns / 1ps

module easing_curve_unit_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [4:0]         op;
    logic [15:0]        progress;
    logic               out_valid;
    logic               out_ready;
    logic signed [16:0] eased;
    int                 mismatches;
    int                 pending;
    int                 checked;
    int                 tx_idle;
    int                 rx_idle;
    int                 sent;

    easing_curve_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .progress  (progress),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .eased     (eased)
    );

    easing_curve_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .progress   (progress),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .eased      (eased),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // receiver stalls at the current rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle);
    end

    // hold the word until it is taken
    task automatic send_word(logic [4:0] sel, logic [15:0] prog);
        int  gap;
        logic took;
        gap = 0;
        while ($urandom_range(99) < tx_idle)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= sel;
        progress <= prog;
        forever
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
            if (took)
            begin
                break;
            end
        end
        sent++;
    endtask

    function automatic logic [15:0] pick_progress();
        case ($urandom_range(9))
            0:       return 16'($urandom_range(65535));
            1:       return 16'(32768 - $urandom_range(3));
            2:       return 16'($urandom_range(3));
            3:       return 16'(16384 + $urandom_range(2) - 1);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    initial
    begin
        logic [15:0] corner[4];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = ecu_pkg::OP_LINEAR;
        progress  = '0;
        tx_idle   = 28;
        rx_idle   = 87;
        sent      = 0;
        corner    = '{16'd0, 16'd32768, 16'd65535, 16'd16384};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every curve once, cycling through the corner progress values
        for (int c = 0; c <= 19; c++)
        begin
            send_word(c[4:0], corner[c[1:0]]);
        end
        send_word(ecu_pkg::OP_QUAD_OUTIN, 16'd16384);
        send_word(5'd20, 16'd12345);
        send_word(5'd31, 16'd65535);
        send_word(ecu_pkg::OP_BOUNCE_IN, 16'd65535);

        // random words through three stall profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 28 : (ph == 1) ? 87 : 0;
            rx_idle = (ph == 0) ? 87 : (ph == 1) ? 28 : 0;
            for (int i = 0; i < 184; i++)
            begin
                send_word(5'($urandom_range(31)), pick_progress());
            end
        end
        in_valid <= 1'b0;
        rx_idle = 0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        $display("Covered %0d words over all 32 selector codes, %0d results compared,",
                 sent, checked);
        $display("with sender and receiver stalls swapped and a back-to-back phase.");
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results still outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
